// ===== rtl/core/lgts_pkg.sv =====
// Shared constants, codes and control types of the LDA Gibbs topic sampler.
package lgts_pkg;

  localparam int MAX_TOPICS  = 32;
  localparam int MAX_VOCAB   = 1024;
  localparam int COUNT_BITS  = 32;
  localparam int RANDOM_BITS = 16;
  localparam int TALLY_BITS  = 16;

  // Port field widths
  localparam int OP_W    = 3;
  localparam int WORD_W  = 11;
  localparam int TOPIC_W = 6;
  localparam int VALUE_W = 32;
  localparam int RF_W    = 16;
  localparam int KIND_W  = 2;
  localparam int ERR_W   = 2;
  localparam int Q8_W    = 16;

  // Index widths
  localparam int TIDX_W    = $clog2(MAX_TOPICS);
  localparam int WIDX_W    = $clog2(MAX_VOCAB);
  localparam int WT_ADDR_W = WIDX_W + TIDX_W;

  // Arithmetic widths: A, B and D are Q.8 with one bit of headroom
  localparam int QA_W        = COUNT_BITS + 9;
  localparam int PROD_W      = 2 * QA_W;
  localparam int MH_W        = (QA_W + 1) / 2;
  localparam int MP_W        = 2 * MH_W;
  localparam int WEIGHT_BITS = 57 - RANDOM_BITS;
  localparam int REM_W       = QA_W + 1;
  localparam int DCNT_W      = $clog2(WEIGHT_BITS + 1);
  localparam int SUM_W       = WEIGHT_BITS + TIDX_W + 1;
  localparam int SH_W        = (SUM_W + 1) / 2;
  localparam int CMP_W       = SUM_W + RANDOM_BITS;
  localparam int KETA_W      = TOPIC_W + Q8_W;

  typedef enum logic [OP_W-1:0] {
    OP_WR_WT  = 3'd0,
    OP_WR_DOC = 3'd1,
    OP_WR_TOT = 3'd2,
    OP_COUNT  = 3'd3,
    OP_SAMPLE = 3'd4,
    OP_FINISH = 3'd5
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK    = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_TALLY  = 2'd2
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_WORD  = 2'd1,
    ERR_TOPIC = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    REG_TOPIC_COUNT = 2'd0,
    REG_VOCAB_SIZE  = 2'd1,
    REG_ALPHA       = 2'd2,
    REG_ETA         = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_CNT_WR, ST_ACK,
    ST_S_RD, ST_S_PREP, ST_S_MUL, ST_S_DINIT, ST_S_DIV, ST_S_ACC,
    ST_S_RMUL, ST_S_RSUM, ST_S_CMP, ST_S_EMIT, ST_S_ERR, ST_FIN
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic apply;
    logic mem_rd_cnt;
    logic mem_rd_smp;
    logic cnt_wr;
    logic j_clear;
    logic j_inc;
    logic prep;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic acc;
    logic rmul;
    logic rsum;
    logic cmp;
    logic emit_ack;
    logic emit_smp;
    logic emit_serr;
    logic emit_tally;
    logic tally_inc;
    logic tally_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic            clear_done;
    logic [OP_W-1:0] op;
    logic            err_any;
    logic            j_last;
    logic            mul_done;
    logic            div_done;
    logic            hit;
    logic            out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/lda_gibbs_topic_sampler.sv =====
// Top level of the LDA Gibbs topic sampler: register port, controller and datapath.
// After reset the block sweeps its 32768-entry word-topic store to zero, one entry
// a cycle, and takes no request until the sweep is done; register writes are taken
// throughout. A sample walks the K topics one at a time; each topic needs the four
// partial products of the weight multiply and the 41-step serial divider, then a
// compare pass over the topics follows and stops at the first hit.
module lda_gibbs_topic_sampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [lgts_pkg::OP_W-1:0]    op,
  input  logic [lgts_pkg::WORD_W-1:0]  word,
  input  logic [lgts_pkg::TOPIC_W-1:0] topic,
  input  logic [lgts_pkg::VALUE_W-1:0] value,
  input  logic [lgts_pkg::RF_W-1:0]    random_fraction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [lgts_pkg::KIND_W-1:0]     kind,
  output logic [lgts_pkg::TOPIC_W-1:0]    result_topic,
  output logic [lgts_pkg::TALLY_BITS-1:0] tally,
  output logic [lgts_pkg::ERR_W-1:0]      error,
  output logic        last
);

  logic [lgts_pkg::TOPIC_W-1:0] topic_count;
  logic [lgts_pkg::WORD_W-1:0]  vocabulary_size;
  logic [lgts_pkg::Q8_W-1:0]    alpha_q8, eta_q8;
  logic [lgts_pkg::TOPIC_W-1:0] k_eff;
  logic [lgts_pkg::WORD_W-1:0]  v_eff;
  logic                         cfg_wr;
  lgts_pkg::dp_cmd_t            cmd;
  lgts_pkg::dp_stat_t           stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      topic_count     <= lgts_pkg::TOPIC_W'(lgts_pkg::MAX_TOPICS);
      vocabulary_size <= lgts_pkg::WORD_W'(lgts_pkg::MAX_VOCAB);
      alpha_q8        <= lgts_pkg::Q8_W'(256);
      eta_q8          <= lgts_pkg::Q8_W'(256);
    end else if (cfg_wr) begin
      case (lgts_pkg::reg_idx_t'(paddr[3:2]))
        lgts_pkg::REG_TOPIC_COUNT: topic_count     <= pwdata[lgts_pkg::TOPIC_W-1:0];
        lgts_pkg::REG_VOCAB_SIZE:  vocabulary_size <= pwdata[lgts_pkg::WORD_W-1:0];
        lgts_pkg::REG_ALPHA:       alpha_q8        <= pwdata[lgts_pkg::Q8_W-1:0];
        lgts_pkg::REG_ETA:         eta_q8          <= pwdata[lgts_pkg::Q8_W-1:0];
        default:                   alpha_q8        <= alpha_q8;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (lgts_pkg::reg_idx_t'(paddr[3:2]))
      lgts_pkg::REG_TOPIC_COUNT: prdata = 32'(topic_count);
      lgts_pkg::REG_VOCAB_SIZE:  prdata = 32'(vocabulary_size);
      lgts_pkg::REG_ALPHA:       prdata = 32'(alpha_q8);
      lgts_pkg::REG_ETA:         prdata = 32'(eta_q8);
      default:                   prdata = '0;
    endcase
  end

  // Clamp topic and vocabulary counts to the supported range
  always_comb begin
    if (topic_count == '0) begin
      k_eff = lgts_pkg::TOPIC_W'(1);
    end else if (topic_count > lgts_pkg::TOPIC_W'(lgts_pkg::MAX_TOPICS)) begin
      k_eff = lgts_pkg::TOPIC_W'(lgts_pkg::MAX_TOPICS);
    end else begin
      k_eff = topic_count;
    end
    if (vocabulary_size > lgts_pkg::WORD_W'(lgts_pkg::MAX_VOCAB)) begin
      v_eff = lgts_pkg::WORD_W'(lgts_pkg::MAX_VOCAB);
    end else begin
      v_eff = vocabulary_size;
    end
  end

  lgts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lgts_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .k_eff           (k_eff),
    .v_eff           (v_eff),
    .alpha_q8        (alpha_q8),
    .eta_q8          (eta_q8),
    .op              (op),
    .word            (word),
    .topic           (topic),
    .value           (value),
    .random_fraction (random_fraction),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .kind            (kind),
    .result_topic    (result_topic),
    .tally           (tally),
    .error           (error),
    .last            (last)
  );

`ifndef SYNTHESIS
  // No request is taken before the store sweep has finished
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> stat.clear_done)
    else $error("request accepted during store clearing");

  // At most one result is loaded per cycle
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_ack, cmd.emit_smp, cmd.emit_serr, cmd.emit_tally}))
    else $error("several results loaded at once");

  // A clean sample names a real topic
  a_sample_topic: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == lgts_pkg::KIND_SAMPLE && error == lgts_pkg::ERR_NONE)
      |-> (result_topic != '0 && result_topic <= k_eff))
    else $error("sampled topic out of range");

  // The result register is only loaded when it is free
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_ack || cmd.emit_smp || cmd.emit_serr || cmd.emit_tally)
      |-> (!out_valid || !out_stall))
    else $error("result overwritten while held");
`endif

endmodule

// ===== rtl/core/lgts_ctrl.sv =====
// Sequencing state machine of the topic sampler: decodes requests and drives the datapath.
module lgts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lgts_pkg::dp_stat_t stat,
  output lgts_pkg::dp_cmd_t  cmd
);

  lgts_pkg::state_t state, state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lgts_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Choose the next state
  always_comb begin
    state_next = state;
    case (state)
      lgts_pkg::ST_CLEAR: begin
        if (stat.clear_done) state_next = lgts_pkg::ST_IDLE;
      end
      lgts_pkg::ST_IDLE: begin
        if (in_valid) state_next = lgts_pkg::ST_DECODE;
      end
      lgts_pkg::ST_DECODE: begin
        case (lgts_pkg::op_t'(stat.op))
          lgts_pkg::OP_FINISH: state_next = lgts_pkg::ST_FIN;
          lgts_pkg::OP_SAMPLE:
            state_next = stat.err_any ? lgts_pkg::ST_S_ERR : lgts_pkg::ST_S_RD;
          lgts_pkg::OP_COUNT:
            state_next = stat.err_any ? lgts_pkg::ST_ACK : lgts_pkg::ST_CNT_WR;
          lgts_pkg::OP_WR_WT, lgts_pkg::OP_WR_DOC, lgts_pkg::OP_WR_TOT:
            state_next = lgts_pkg::ST_ACK;
          default: state_next = lgts_pkg::ST_IDLE;
        endcase
      end
      lgts_pkg::ST_CNT_WR:  state_next = lgts_pkg::ST_ACK;
      lgts_pkg::ST_ACK: begin
        if (stat.out_free) state_next = lgts_pkg::ST_IDLE;
      end
      lgts_pkg::ST_S_RD:    state_next = lgts_pkg::ST_S_PREP;
      lgts_pkg::ST_S_PREP:  state_next = lgts_pkg::ST_S_MUL;
      lgts_pkg::ST_S_MUL: begin
        if (stat.mul_done) state_next = lgts_pkg::ST_S_DINIT;
      end
      lgts_pkg::ST_S_DINIT: state_next = lgts_pkg::ST_S_DIV;
      lgts_pkg::ST_S_DIV: begin
        if (stat.div_done) state_next = lgts_pkg::ST_S_ACC;
      end
      lgts_pkg::ST_S_ACC:
        state_next = stat.j_last ? lgts_pkg::ST_S_RMUL : lgts_pkg::ST_S_RD;
      lgts_pkg::ST_S_RMUL:  state_next = lgts_pkg::ST_S_RSUM;
      lgts_pkg::ST_S_RSUM:  state_next = lgts_pkg::ST_S_CMP;
      lgts_pkg::ST_S_CMP: begin
        if (stat.hit || stat.j_last) state_next = lgts_pkg::ST_S_EMIT;
      end
      lgts_pkg::ST_S_EMIT, lgts_pkg::ST_S_ERR: begin
        if (stat.out_free) state_next = lgts_pkg::ST_IDLE;
      end
      lgts_pkg::ST_FIN: begin
        if (stat.out_free && stat.j_last) state_next = lgts_pkg::ST_IDLE;
      end
      default: state_next = lgts_pkg::ST_IDLE;
    endcase
  end

  // Drive datapath commands and the input stall
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      lgts_pkg::ST_CLEAR: begin
        cmd.clr_step = !stat.clear_done;
      end
      lgts_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      lgts_pkg::ST_DECODE: begin
        case (lgts_pkg::op_t'(stat.op))
          lgts_pkg::OP_FINISH: cmd.j_clear = 1'b1;
          lgts_pkg::OP_SAMPLE: cmd.j_clear = !stat.err_any;
          lgts_pkg::OP_COUNT:  cmd.mem_rd_cnt = !stat.err_any;
          lgts_pkg::OP_WR_WT, lgts_pkg::OP_WR_DOC, lgts_pkg::OP_WR_TOT:
            cmd.apply = !stat.err_any;
          default: cmd.apply = 1'b0;
        endcase
      end
      lgts_pkg::ST_CNT_WR:  cmd.cnt_wr = 1'b1;
      lgts_pkg::ST_ACK:     cmd.emit_ack = stat.out_free;
      lgts_pkg::ST_S_RD:    cmd.mem_rd_smp = 1'b1;
      lgts_pkg::ST_S_PREP:  cmd.prep = 1'b1;
      lgts_pkg::ST_S_MUL:   cmd.mul_step = 1'b1;
      lgts_pkg::ST_S_DINIT: cmd.div_init = 1'b1;
      lgts_pkg::ST_S_DIV:   cmd.div_step = !stat.div_done;
      lgts_pkg::ST_S_ACC: begin
        cmd.acc   = 1'b1;
        cmd.j_inc = !stat.j_last;
      end
      lgts_pkg::ST_S_RMUL:  cmd.rmul = 1'b1;
      lgts_pkg::ST_S_RSUM: begin
        cmd.rsum    = 1'b1;
        cmd.j_clear = 1'b1;
      end
      lgts_pkg::ST_S_CMP: begin
        cmd.cmp   = 1'b1;
        cmd.j_inc = !(stat.hit || stat.j_last);
      end
      lgts_pkg::ST_S_EMIT: begin
        cmd.emit_smp  = stat.out_free;
        cmd.tally_inc = stat.out_free;
      end
      lgts_pkg::ST_S_ERR:   cmd.emit_serr = stat.out_free;
      lgts_pkg::ST_FIN: begin
        cmd.emit_tally  = stat.out_free;
        cmd.tally_clear = stat.out_free && stat.j_last;
        cmd.j_inc       = stat.out_free && !stat.j_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/lgts_dp.sv =====
// Datapath of the topic sampler: count stores, weight arithmetic, serial divider, result register.
module lgts_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  lgts_pkg::dp_cmd_t             cmd,
  output lgts_pkg::dp_stat_t            stat,
  input  logic [lgts_pkg::TOPIC_W-1:0]  k_eff,
  input  logic [lgts_pkg::WORD_W-1:0]   v_eff,
  input  logic [lgts_pkg::Q8_W-1:0]     alpha_q8,
  input  logic [lgts_pkg::Q8_W-1:0]     eta_q8,
  input  logic [lgts_pkg::OP_W-1:0]     op,
  input  logic [lgts_pkg::WORD_W-1:0]   word,
  input  logic [lgts_pkg::TOPIC_W-1:0]  topic,
  input  logic [lgts_pkg::VALUE_W-1:0]  value,
  input  logic [lgts_pkg::RF_W-1:0]     random_fraction,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [lgts_pkg::KIND_W-1:0]   kind,
  output logic [lgts_pkg::TOPIC_W-1:0]  result_topic,
  output logic [lgts_pkg::TALLY_BITS-1:0] tally,
  output logic [lgts_pkg::ERR_W-1:0]    error,
  output logic                          last
);

  localparam int CW = lgts_pkg::COUNT_BITS;

  // Latched request
  logic [lgts_pkg::OP_W-1:0]    op_r;
  logic [lgts_pkg::WORD_W-1:0]  word_r;
  logic [lgts_pkg::TOPIC_W-1:0] topic_r;
  logic [CW-1:0]                value_r;
  logic [lgts_pkg::RF_W-1:0]    rf_r;
  logic [lgts_pkg::ERR_W-1:0]   err_r;
  logic [lgts_pkg::ERR_W-1:0]   err_in;
  logic                         word_ok, topic_ok;
  logic [lgts_pkg::WORD_W-1:0]  word_m1;
  logic [lgts_pkg::TOPIC_W-1:0] topic_m1;
  logic [lgts_pkg::WIDX_W-1:0]  widx;
  logic [lgts_pkg::TIDX_W-1:0]  tidx;

  // Word-topic memory and clearing pass
  logic [CW-1:0] wt_mem [0:(1 << lgts_pkg::WT_ADDR_W)-1];
  logic [CW-1:0]                   wt_rdata;
  logic [lgts_pkg::WT_ADDR_W:0]    clr_addr;
  logic                            mem_we, mem_re;
  logic [lgts_pkg::WT_ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [CW-1:0]                   mem_wdata, wt_inc;

  // Small per-topic stores
  logic [CW-1:0] doc_cnt [lgts_pkg::MAX_TOPICS];
  logic [CW-1:0] tot_cnt [lgts_pkg::MAX_TOPICS];
  logic [lgts_pkg::TALLY_BITS-1:0] tally_arr [lgts_pkg::MAX_TOPICS];
  logic [lgts_pkg::SUM_W-1:0]      cum [lgts_pkg::MAX_TOPICS];

  // Topic walk and arithmetic
  logic [lgts_pkg::TIDX_W-1:0]  j;
  logic [lgts_pkg::TOPIC_W-1:0] j_p1;
  logic [CW-1:0]                w_adj, d_adj;
  logic [lgts_pkg::KETA_W-1:0]  keta;
  logic [lgts_pkg::QA_W-1:0]    a_next, b_next, den_next;
  logic [lgts_pkg::QA_W-1:0]    a_r, b_r, d_r;
  logic [2:0]                   mph;
  logic [1:0]                   prev_ph;
  logic [lgts_pkg::MH_W-1:0]    pa, pb;
  logic [lgts_pkg::MP_W-1:0]    prod_r;
  logic [lgts_pkg::PROD_W-1:0]  prod_sh, acc_p;
  logic                         sat;
  logic [lgts_pkg::REM_W-1:0]   rem, rs;
  logic [lgts_pkg::WEIGHT_BITS-1:0] dsh, q;
  logic [lgts_pkg::DCNT_W-1:0]  dcnt;
  logic [lgts_pkg::SUM_W-1:0]   total, total_next;
  logic [lgts_pkg::SH_W+lgts_pkg::RF_W-1:0] p_lo, p_hi;
  logic [lgts_pkg::CMP_W-1:0]   thr, cum_sh;
  logic [lgts_pkg::TOPIC_W-1:0] sel_r, sel_m1;
  logic                         hit;

  // Range checks on the incoming request
  always_comb begin
    word_ok  = (word != '0) && (word <= v_eff);
    topic_ok = (topic != '0) && (topic <= k_eff);
    if (op == lgts_pkg::OP_WR_DOC || op == lgts_pkg::OP_WR_TOT) begin
      err_in = topic_ok ? lgts_pkg::ERR_NONE : lgts_pkg::ERR_TOPIC;
    end else if (!word_ok) begin
      err_in = lgts_pkg::ERR_WORD;
    end else begin
      err_in = topic_ok ? lgts_pkg::ERR_NONE : lgts_pkg::ERR_TOPIC;
    end
  end

  assign word_m1  = word_r - lgts_pkg::WORD_W'(1);
  assign topic_m1 = topic_r - lgts_pkg::TOPIC_W'(1);
  assign widx     = word_m1[lgts_pkg::WIDX_W-1:0];
  assign tidx     = topic_m1[lgts_pkg::TIDX_W-1:0];
  assign j_p1     = lgts_pkg::TOPIC_W'(j) + lgts_pkg::TOPIC_W'(1);

  // Memory port selection
  assign wt_inc    = (wt_rdata == '1) ? wt_rdata : wt_rdata + CW'(1);
  assign mem_we    = cmd.clr_step || cmd.cnt_wr ||
                     (cmd.apply && op_r == lgts_pkg::OP_WR_WT);
  assign mem_waddr = cmd.clr_step ? clr_addr[lgts_pkg::WT_ADDR_W-1:0] : {widx, tidx};
  assign mem_wdata = cmd.clr_step ? '0 : (cmd.cnt_wr ? wt_inc : value_r);
  assign mem_re    = cmd.mem_rd_cnt || cmd.mem_rd_smp;
  assign mem_raddr = cmd.mem_rd_cnt ? {widx, tidx} : {widx, j};

  always_ff @(posedge clk) begin
    if (mem_we) wt_mem[mem_waddr] <= mem_wdata;
    if (mem_re) wt_rdata <= wt_mem[mem_raddr];
  end

  // Weight operands, own contribution removed at the current topic
  always_comb begin
    w_adj = wt_rdata;
    d_adj = doc_cnt[j];
    if (j == tidx) begin
      if (w_adj != '0) w_adj = w_adj - CW'(1);
      if (d_adj != '0) d_adj = d_adj - CW'(1);
    end
    keta     = k_eff * eta_q8;
    a_next   = {1'b0, d_adj, 8'h00} + lgts_pkg::QA_W'(alpha_q8);
    b_next   = {1'b0, w_adj, 8'h00} + lgts_pkg::QA_W'(eta_q8);
    den_next = {1'b0, tot_cnt[j], 8'h00} + lgts_pkg::QA_W'(keta);
    if (den_next == '0) den_next = lgts_pkg::QA_W'(1);
  end

  // Partial product operands and placement
  always_comb begin
    pa = mph[1] ? lgts_pkg::MH_W'(a_r[lgts_pkg::QA_W-1:lgts_pkg::MH_W]) :
                  a_r[lgts_pkg::MH_W-1:0];
    pb = mph[0] ? lgts_pkg::MH_W'(b_r[lgts_pkg::QA_W-1:lgts_pkg::MH_W]) :
                  b_r[lgts_pkg::MH_W-1:0];
    case (prev_ph)
      2'd0:    prod_sh = lgts_pkg::PROD_W'(prod_r);
      2'd3:    prod_sh = lgts_pkg::PROD_W'(prod_r) << (2 * lgts_pkg::MH_W);
      default: prod_sh = lgts_pkg::PROD_W'(prod_r) << lgts_pkg::MH_W;
    endcase
  end

  // Divider step and cumulative compare
  assign sat        = acc_p >= (lgts_pkg::PROD_W'(d_r) << lgts_pkg::WEIGHT_BITS);
  assign rs         = {rem[lgts_pkg::QA_W-1:0], dsh[lgts_pkg::WEIGHT_BITS-1]};
  assign total_next = total + lgts_pkg::SUM_W'(q);
  assign cum_sh     = {cum[j], {lgts_pkg::RANDOM_BITS{1'b0}}};
  assign hit        = cum_sh > thr;
  assign sel_m1     = sel_r - lgts_pkg::TOPIC_W'(1);

  // Control and count state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      j         <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < lgts_pkg::MAX_TOPICS; i++) begin
        doc_cnt[i]   <= '0;
        tot_cnt[i]   <= '0;
        tally_arr[i] <= '0;
      end
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.j_clear) begin
        j <= '0;
      end else if (cmd.j_inc) begin
        j <= j + 1'b1;
      end
      if (cmd.apply && op_r == lgts_pkg::OP_WR_DOC) doc_cnt[tidx] <= value_r;
      if (cmd.apply && op_r == lgts_pkg::OP_WR_TOT) tot_cnt[tidx] <= value_r;
      if (cmd.tally_inc && tally_arr[sel_m1[lgts_pkg::TIDX_W-1:0]] != '1) begin
        tally_arr[sel_m1[lgts_pkg::TIDX_W-1:0]] <=
          tally_arr[sel_m1[lgts_pkg::TIDX_W-1:0]] + 1'b1;
      end
      if (cmd.tally_clear) begin
        for (int i = 0; i < lgts_pkg::MAX_TOPICS; i++) tally_arr[i] <= '0;
      end
      // Hold the result until taken
      if (cmd.emit_ack || cmd.emit_smp || cmd.emit_serr || cmd.emit_tally) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op;
      word_r  <= word;
      topic_r <= topic;
      value_r <= value;
      rf_r    <= random_fraction;
      err_r   <= err_in;
    end
    if (cmd.j_clear) total <= '0;
    if (cmd.prep) begin
      a_r   <= a_next;
      b_r   <= b_next;
      d_r   <= den_next;
      mph   <= '0;
      acc_p <= '0;
    end
    // Four partial products, each added in the cycle after it is formed
    if (cmd.mul_step) begin
      if (mph != 3'd4) begin
        prod_r  <= pa * pb;
        prev_ph <= mph[1:0];
      end
      if (mph != 3'd0) acc_p <= acc_p + prod_sh;
      mph <= mph + 3'd1;
    end
    if (cmd.div_init) begin
      rem  <= lgts_pkg::REM_W'(acc_p[lgts_pkg::PROD_W-1:lgts_pkg::WEIGHT_BITS]);
      dsh  <= acc_p[lgts_pkg::WEIGHT_BITS-1:0];
      q    <= sat ? '1 : '0;
      dcnt <= sat ? '0 : lgts_pkg::DCNT_W'(lgts_pkg::WEIGHT_BITS);
    end
    // One quotient bit per cycle
    if (cmd.div_step) begin
      if (rs >= {1'b0, d_r}) begin
        rem <= rs - {1'b0, d_r};
        q   <= {q[lgts_pkg::WEIGHT_BITS-2:0], 1'b1};
      end else begin
        rem <= rs;
        q   <= {q[lgts_pkg::WEIGHT_BITS-2:0], 1'b0};
      end
      dsh  <= dsh << 1;
      dcnt <= dcnt - 1'b1;
    end
    if (cmd.acc) begin
      total  <= total_next;
      cum[j] <= total_next;
    end
    if (cmd.rmul) begin
      p_lo <= rf_r * total[lgts_pkg::SH_W-1:0];
      p_hi <= rf_r * lgts_pkg::SH_W'(total[lgts_pkg::SUM_W-1:lgts_pkg::SH_W]);
    end
    if (cmd.rsum) begin
      thr <= lgts_pkg::CMP_W'(p_lo) + (lgts_pkg::CMP_W'(p_hi) << lgts_pkg::SH_W);
    end
    if (cmd.cmp) sel_r <= hit ? j_p1 : k_eff;
    // Load the result register
    if (cmd.emit_ack) begin
      kind         <= lgts_pkg::KIND_ACK;
      result_topic <= '0;
      tally        <= '0;
      error        <= err_r;
      last         <= 1'b1;
    end else if (cmd.emit_smp) begin
      kind         <= lgts_pkg::KIND_SAMPLE;
      result_topic <= sel_r;
      tally        <= '0;
      error        <= lgts_pkg::ERR_NONE;
      last         <= 1'b1;
    end else if (cmd.emit_serr) begin
      kind         <= lgts_pkg::KIND_SAMPLE;
      result_topic <= '0;
      tally        <= '0;
      error        <= err_r;
      last         <= 1'b1;
    end else if (cmd.emit_tally) begin
      kind         <= lgts_pkg::KIND_TALLY;
      result_topic <= j_p1;
      tally        <= tally_arr[j];
      error        <= lgts_pkg::ERR_NONE;
      last         <= stat.j_last;
    end
  end

  // Report status to the controller
  always_comb begin
    stat.clear_done = clr_addr[lgts_pkg::WT_ADDR_W];
    stat.op         = op_r;
    stat.err_any    = err_r != lgts_pkg::ERR_NONE;
    stat.j_last     = lgts_pkg::TOPIC_W'(j) == (k_eff - lgts_pkg::TOPIC_W'(1));
    stat.mul_done   = mph == 3'd4;
    stat.div_done   = dcnt == '0;
    stat.hit        = hit;
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the LDA Gibbs topic sampler: driver, monitor and count predictor.
module testbench;
  import lgts_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam logic [127:0] WEIGHT_CAP = (128'd1 << WEIGHT_BITS) - 1;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [WORD_W-1:0]  word;
    logic [TOPIC_W-1:0] topic;
    logic [VALUE_W-1:0] value;
    logic [RF_W-1:0]    rf;
  } request_t;

  typedef struct {
    logic [KIND_W-1:0]     kind;
    logic [TOPIC_W-1:0]    topic;
    logic [TALLY_BITS-1:0] tally;
    logic [ERR_W-1:0]      err;
    logic                  last;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0]    op = '0;
  logic [WORD_W-1:0]  word = '0;
  logic [TOPIC_W-1:0] topic = '0;
  logic [VALUE_W-1:0] value = '0;
  logic [RF_W-1:0]    random_fraction = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KIND_W-1:0]     kind;
  logic [TOPIC_W-1:0]    result_topic;
  logic [TALLY_BITS-1:0] tally;
  logic [ERR_W-1:0]      error;
  logic last;

  lda_gibbs_topic_sampler dut (.*);

  // Predictor state
  logic [31:0] wt_cnt [MAX_VOCAB*MAX_TOPICS];
  logic [31:0] doc_cnt [MAX_TOPICS];
  logic [31:0] tot_cnt [MAX_TOPICS];
  logic [15:0] tally_cnt [MAX_TOPICS];
  logic [5:0]  k_reg = 6'd32;
  logic [10:0] v_reg = 11'd1024;
  logic [15:0] alpha_reg = 16'd256, eta_reg = 16'd256;

  request_t pending_q[$];
  answer_t  answer_q[$];
  request_t cur;
  int errors = 0, n_req = 0, n_ans = 0, n_draws = 0;
  int in_gap = 0, out_hold = 0;
  bit taken = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int draw_wait();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic void add_answer(input logic [KIND_W-1:0] kd, input logic [TOPIC_W-1:0] tp,
                                     input logic [15:0] tl, input logic [ERR_W-1:0] er,
                                     input logic lt);
    answer_t a;
    a.kind = kd; a.topic = tp; a.tally = tl; a.err = er; a.last = lt;
    answer_q.push_back(a);
  endfunction

  // Draw a new topic from the collapsed conditional
  function automatic int draw_topic(input int widx, input int cur_t, input logic [15:0] rf,
                                    input int k);
    logic [127:0] cum [MAX_TOPICS];
    logic [127:0] a, b, den, q, total, w, d;
    int sel;
    total = 0;
    for (int j = 0; j < k; j++) begin
      w = wt_cnt[widx*MAX_TOPICS + j];
      d = doc_cnt[j];
      if (j == cur_t) begin
        if (w > 0) w = w - 1;
        if (d > 0) d = d - 1;
      end
      a = (d << 8) + alpha_reg;
      b = (w << 8) + eta_reg;
      den = (128'(tot_cnt[j]) << 8) + 128'(k) * eta_reg;
      if (den == 0) den = 1;
      q = (a * b) / den;
      if (q > WEIGHT_CAP) q = WEIGHT_CAP;
      total = total + q;
      cum[j] = total;
    end
    sel = k;
    for (int j = k - 1; j >= 0; j--)
      if ((cum[j] << RANDOM_BITS) > 128'(rf) * total) sel = j + 1;
    return sel;
  endfunction

  // Work out the answers of one accepted request and update the counts
  task automatic predict_request(input request_t r);
    int k, v, sel, slot;
    bit word_ok, topic_ok;
    logic [ERR_W-1:0] er;
    k = (k_reg == 0) ? 1 : ((k_reg > MAX_TOPICS) ? MAX_TOPICS : k_reg);
    v = (v_reg > MAX_VOCAB) ? MAX_VOCAB : v_reg;
    word_ok = r.word >= 1 && r.word <= v;
    topic_ok = r.topic >= 1 && r.topic <= k;
    if (r.op == OP_FINISH) begin
      for (int j = 0; j < k; j++) begin
        add_answer(KIND_TALLY, TOPIC_W'(j + 1), tally_cnt[j], ERR_NONE, j + 1 == k);
        tally_cnt[j] = 0;
      end
      for (int j = k; j < MAX_TOPICS; j++) tally_cnt[j] = 0;
      return;
    end
    if (r.op == OP_SPARE_LO || r.op == OP_SPARE_HI) return;
    if (r.op == OP_WR_DOC || r.op == OP_WR_TOT) er = topic_ok ? ERR_NONE : ERR_TOPIC;
    else er = !word_ok ? ERR_WORD : (!topic_ok ? ERR_TOPIC : ERR_NONE);
    if (r.op == OP_SAMPLE) begin
      if (er != ERR_NONE) begin
        add_answer(KIND_SAMPLE, '0, '0, er, 1'b1);
        return;
      end
      sel = draw_topic(r.word - 1, r.topic - 1, r.rf, k);
      if (tally_cnt[sel-1] != 16'hFFFF) tally_cnt[sel-1]++;
      add_answer(KIND_SAMPLE, TOPIC_W'(sel), '0, ERR_NONE, 1'b1);
      n_draws++;
      return;
    end
    if (er == ERR_NONE) begin
      slot = (r.word - 1) * MAX_TOPICS + (r.topic - 1);
      case (r.op)
        OP_WR_WT:  wt_cnt[slot] = r.value;
        OP_WR_DOC: doc_cnt[r.topic-1] = r.value;
        OP_WR_TOT: tot_cnt[r.topic-1] = r.value;
        default: if (wt_cnt[slot] != 32'hFFFF_FFFF) wt_cnt[slot]++;
      endcase
    end
    add_answer(KIND_ACK, '0, '0, er, 1'b1);
  endtask

  // Note acceptance of a request
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_request(cur);
      n_req++;
      taken = 1;
    end
  end

  // Drive requests from the pending queue at the falling edge
  always @(negedge clk) begin
    logic nv;
    nv = in_valid;
    if (taken) begin
      taken = 0;
      nv = 1'b0;
      in_gap = draw_wait();
    end
    if (!nv) begin
      if (in_gap > 0) in_gap--;
      else if (pending_q.size() > 0) begin
        cur = pending_q.pop_front();
        op <= cur.op; word <= cur.word; topic <= cur.topic;
        value <= cur.value; random_fraction <= cur.rf;
        nv = 1'b1;
      end
    end
    in_valid <= nv;
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each accepted answer against the oldest expectation
  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && !out_stall) begin
      n_ans++;
      out_hold = draw_wait();
      if (answer_q.size() == 0) begin
        report($sformatf("unexpected answer kind %0d topic %0d", kind, result_topic));
      end else begin
        e = answer_q.pop_front();
        if (kind !== e.kind) report($sformatf("kind %0d, want %0d", kind, e.kind));
        if (result_topic !== e.topic)
          report($sformatf("topic %0d, want %0d", result_topic, e.topic));
        if (tally !== e.tally) report($sformatf("tally %0d, want %0d", tally, e.tally));
        if (error !== e.err) report($sformatf("error %0d, want %0d", error, e.err));
        if (last !== e.last) report($sformatf("last %0d, want %0d", last, e.last));
      end
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_TOPIC_COUNT: k_reg = data[5:0];
      REG_VOCAB_SIZE:  v_reg = data[10:0];
      REG_ALPHA:       alpha_reg = data[15:0];
      default:         eta_reg = data[15:0];
    endcase
  endtask

  task automatic set_regs(input logic [31:0] k, input logic [31:0] v,
                          input logic [31:0] al, input logic [31:0] et);
    reg_write(REG_TOPIC_COUNT, k);
    reg_write(REG_VOCAB_SIZE, v);
    reg_write(REG_ALPHA, al);
    reg_write(REG_ETA, et);
  endtask

  task automatic push(input logic [OP_W-1:0] o, input int w, input int t,
                      input logic [31:0] val, input logic [15:0] rf);
    request_t r;
    r.op = o; r.word = WORD_W'(w); r.topic = TOPIC_W'(t); r.value = val; r.rf = rf;
    pending_q.push_back(r);
  endtask

  // Hold until every request is in and answered, then let the block go idle
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || answer_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      2: return 0;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  // One well-formed document pass with random content, plus some noise
  task automatic doc_pass(input int k, input int v);
    int w;
    for (int t = 1; t <= k && t <= 8; t++) begin
      push(OP_WR_DOC, $urandom_range(0, 2047), t, rand_count(), $urandom);
      push(OP_WR_TOT, $urandom_range(0, 2047), t, rand_count(), $urandom);
    end
    for (int i = 0; i < 3; i++)
      push(OP_WR_WT, $urandom_range(1, v), $urandom_range(1, k), rand_count(), $urandom);
    for (int i = 0; i < 2; i++)
      push(OP_COUNT, $urandom_range(1, v), $urandom_range(1, k), $urandom, $urandom);
    for (int i = 0; i < 6; i++) begin
      w = $urandom_range(1, v);
      push(OP_SAMPLE, w, $urandom_range(1, k), $urandom, $urandom);
    end
    push(OP_W'($urandom_range(0, 7)), $urandom_range(0, 2047), $urandom_range(0, 63),
         $urandom, $urandom);
    push(OP_FINISH, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int k, v;
    for (int i = 0; i < MAX_VOCAB*MAX_TOPICS; i++) wt_cnt[i] = 0;
    for (int i = 0; i < MAX_TOPICS; i++) begin
      doc_cnt[i] = 0; tot_cnt[i] = 0; tally_cnt[i] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: four topics, sixteen words, field extremes and error cases
    set_regs(4, 16, 256, 256);
    push(OP_WR_WT, 1, 1, 32'hFFFF_FFFF, 0);
    push(OP_COUNT, 1, 1, 0, 0);
    push(OP_COUNT, 16, 4, 0, 0);
    push(OP_WR_WT, 0, 1, 5, 0);
    push(OP_WR_WT, 17, 1, 5, 0);
    push(OP_COUNT, 2047, 63, 5, 0);
    push(OP_WR_DOC, 2047, 0, 9, 0);
    push(OP_WR_DOC, 0, 2, 7, 0);
    push(OP_WR_TOT, 1500, 5, 3, 0);
    push(OP_WR_TOT, 0, 2, 32'hFFFF_FFFF, 0);
    push(OP_SPARE_LO, 3, 3, 3, 3);
    push(OP_SPARE_HI, 2047, 63, 32'hFFFF_FFFF, 16'hFFFF);
    push(OP_SAMPLE, 0, 1, 0, 0);
    push(OP_SAMPLE, 3, 63, 0, 0);
    push(OP_SAMPLE, 1, 1, 0, 0);
    push(OP_SAMPLE, 1, 1, 0, 16'hFFFF);
    push(OP_SAMPLE, 16, 2, 0, 16'h8000);
    push(OP_FINISH, 0, 0, 0, 0);
    drain();

    // Topic count zero clamps to one; zero parameters give zero weights and denominators
    set_regs(0, 2047, 0, 0);
    push(OP_SAMPLE, 1024, 1, 0, 16'h1234);
    push(OP_SAMPLE, 1025, 1, 0, 0);
    push(OP_WR_WT, 1024, 1, 1, 0);
    push(OP_SAMPLE, 1024, 1, 0, 16'hFFFF);
    push(OP_FINISH, 0, 0, 0, 0);
    drain();

    // Topic count above range clamps to the maximum, largest parameters
    set_regs(63, 1024, 16'hFFFF, 16'hFFFF);
    push(OP_WR_DOC, 0, 32, 32'hFFFF_FFFF, 0);
    push(OP_WR_WT, 1024, 32, 32'hFFFF_FFFF, 0);
    push(OP_SAMPLE, 1024, 32, 0, 16'hFFFF);
    push(OP_SAMPLE, 1024, 1, 0, 0);
    push(OP_FINISH, 0, 0, 0, 0);
    drain();

    // Random document passes over varied settings
    for (int p = 0; p < 3; p++) begin
      k = $urandom_range(1, 6);
      v = $urandom_range(1, 40);
      if (p == 2) begin
        k = 32;
        v = 1024;
      end
      set_regs(k, v, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024),
               $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024));
      doc_pass(k, v);
      drain();
    end

    $display("covered %0d requests and %0d answers, %0d topic draws", n_req, n_ans, n_draws);
    $display("register settings included clamped, zero and full-scale values");
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Give up after a generous time
  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
